/* design/tlc_pkg.sv */
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types, codes and reset values for the trajectory limit checker.
// ----------------------------------------------------------------------------
package tlc_pkg;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef logic signed [MUL_A_W-1:0] mul_a_type;
   typedef logic signed [MUL_B_W-1:0] mul_b_type;
   typedef logic signed [MUL_P_W-1:0] mul_p_type;

   typedef logic [2:0] verdict_type;
   typedef logic [1:0] fail_type;

   localparam verdict_type VERDICT_VALID = 3'd0;
   localparam verdict_type VERDICT_PAIR_BASE = 3'd3;

   localparam fail_type POINT_NONE      = 2'd0;
   localparam fail_type POINT_SPEED     = 2'd1;
   localparam fail_type POINT_ACCEL     = 2'd2;
   localparam fail_type POINT_CURVATURE = 2'd3;

   localparam fail_type PAIR_NONE    = 2'd0;
   localparam fail_type PAIR_JERK    = 2'd1;
   localparam fail_type PAIR_LATERAL = 2'd2;

   localparam logic [2:0] CSR_HORIZON_MS          = 3'd0;
   localparam logic [2:0] CSR_SPEED_UPPER         = 3'd1;
   localparam logic [2:0] CSR_ACCEL_LOWER         = 3'd2;
   localparam logic [2:0] CSR_ACCEL_UPPER         = 3'd3;
   localparam logic [2:0] CSR_CURVATURE_BOUND     = 3'd4;
   localparam logic [2:0] CSR_JERK_LOWER          = 3'd5;
   localparam logic [2:0] CSR_JERK_UPPER          = 3'd6;
   localparam logic [2:0] CSR_LATERAL_ACCEL_BOUND = 3'd7;

   localparam logic        [15:0] RST_HORIZON_MS          = 16'd8000;
   localparam logic signed [15:0] RST_SPEED_UPPER         = 16'sd10240;
   localparam logic signed [15:0] RST_ACCEL_LOWER         = -16'sd1536;
   localparam logic signed [15:0] RST_ACCEL_UPPER         = 16'sd1024;
   localparam logic        [14:0] RST_CURVATURE_BOUND     = 15'd811;
   localparam logic signed [15:0] RST_JERK_LOWER          = -16'sd1024;
   localparam logic signed [15:0] RST_JERK_UPPER          = 16'sd512;
   localparam logic        [14:0] RST_LATERAL_ACCEL_BOUND = 15'd1024;

   localparam logic signed [15:0] SPEED_LOWER_DEFAULT = -16'sd26;

endpackage

/* design/tlc_mul.sv */
// ----------------------------------------------------------------------------
// tlc_mul
// Shared signed multiplier with a registered product and a hold enable.
// ----------------------------------------------------------------------------
module tlc_mul (
   input  logic               clock,
   input  logic               enable,
   input  tlc_pkg::mul_a_type op_a,
   input  tlc_pkg::mul_b_type op_b,
   output tlc_pkg::mul_p_type product
);

   tlc_pkg::mul_p_type product_ff;
   tlc_pkg::mul_p_type product_in;

   assign product_in = tlc_pkg::MUL_P_W'(op_a) * tlc_pkg::MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

/* design/trajectory_limit_checker.sv */
// ----------------------------------------------------------------------------
// trajectory_limit_checker
// Streams trajectory points, checks point and pair limits, and returns one
// verdict on the point marked last.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  time_ms speed accel curvature
//                                              last_point
//   rsp      out        rsp_valid / rsp_ready  verdict
//   csr      in         csr_write_enable       csr_index csr_write_data
//
// Each point steps through states MK, JL, JU and EVAL; four products (v*v,
// v*v*k, two jerk bounds times dt) go in turn through the shared multiplier.
// The next point is taken in the cycle the current one completes.
// A last point holds in its final cycle while an earlier verdict waits.
// Reset loads the register defaults and clears the trajectory state.
// ----------------------------------------------------------------------------
module trajectory_limit_checker #(
   parameter logic signed [15:0] SPEED_LOWER = tlc_pkg::SPEED_LOWER_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic        [15:0] req_time_ms,
   input  logic signed [15:0] req_speed,
   input  logic signed [15:0] req_accel,
   input  logic signed [15:0] req_curvature,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [2:0]  rsp_verdict,
   input  logic               csr_write_enable,
   input  logic        [2:0]  csr_index,
   input  logic        [15:0] csr_write_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MK   = 3'd1;
   localparam logic [2:0] ST_JL   = 3'd2;
   localparam logic [2:0] ST_JU   = 3'd3;
   localparam logic [2:0] ST_EVAL = 3'd4;

   logic        [15:0] horizon_ff;
   logic signed [15:0] speed_upper_ff;
   logic signed [15:0] accel_lower_ff;
   logic signed [15:0] accel_upper_ff;
   logic        [14:0] curv_bound_ff;
   logic signed [15:0] jerk_lower_ff;
   logic signed [15:0] jerk_upper_ff;
   logic        [14:0] lat_bound_ff;

   logic [2:0] state_ff, state_in;

   logic        [15:0] t_ff;
   logic signed [15:0] v_ff;
   logic signed [15:0] a_ff;
   logic signed [15:0] k_ff;
   logic               last_ff;

   logic signed [16:0] dt_ff, dt_in;
   logic signed [26:0] lhs_ff, lhs_in;
   logic signed [47:0] lat_ff;
   logic signed [33:0] lo_ff;

   logic        [15:0] prev_time_ff, prev_time_in;
   logic signed [15:0] prev_accel_ff, prev_accel_in;
   logic               have_prev_ff, have_prev_in;
   logic               pstop_ff, pstop_in;
   logic               qstop_ff, qstop_in;
   tlc_pkg::fail_type  pfail_ff, pfail_in;
   tlc_pkg::fail_type  qfail_ff, qfail_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   tlc_pkg::verdict_type verdict_ff, verdict_in;

   tlc_pkg::mul_a_type op_a;
   tlc_pkg::mul_b_type op_b;
   tlc_pkg::mul_p_type product;

   logic finish;
   logic accept;
   logic mul_enable;

   logic signed [16:0] da;
   logic signed [26:0] da_ext;
   logic signed [33:0] lhs_ext;
   logic signed [33:0] hi;
   logic signed [47:0] lat_bound;
   logic signed [15:0] curv_bound_s;
   logic               past;
   logic               jerk_fail;
   logic               lat_fail;
   tlc_pkg::fail_type  point_code;
   tlc_pkg::fail_type  pair_code;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff     <= tlc_pkg::RST_HORIZON_MS;
         speed_upper_ff <= tlc_pkg::RST_SPEED_UPPER;
         accel_lower_ff <= tlc_pkg::RST_ACCEL_LOWER;
         accel_upper_ff <= tlc_pkg::RST_ACCEL_UPPER;
         curv_bound_ff  <= tlc_pkg::RST_CURVATURE_BOUND;
         jerk_lower_ff  <= tlc_pkg::RST_JERK_LOWER;
         jerk_upper_ff  <= tlc_pkg::RST_JERK_UPPER;
         lat_bound_ff   <= tlc_pkg::RST_LATERAL_ACCEL_BOUND;
      end else if (csr_write_enable) begin
         case (csr_index)
            tlc_pkg::CSR_HORIZON_MS:          horizon_ff     <= csr_write_data;
            tlc_pkg::CSR_SPEED_UPPER:         speed_upper_ff <= csr_write_data;
            tlc_pkg::CSR_ACCEL_LOWER:         accel_lower_ff <= csr_write_data;
            tlc_pkg::CSR_ACCEL_UPPER:         accel_upper_ff <= csr_write_data;
            tlc_pkg::CSR_CURVATURE_BOUND:     curv_bound_ff  <= csr_write_data[14:0];
            tlc_pkg::CSR_JERK_LOWER:          jerk_lower_ff  <= csr_write_data;
            tlc_pkg::CSR_JERK_UPPER:          jerk_upper_ff  <= csr_write_data;
            tlc_pkg::CSR_LATERAL_ACCEL_BOUND: lat_bound_ff   <= csr_write_data[14:0];
            default: ;
         endcase
      end
   end

   // sequencer
   assign finish     = (state_ff == ST_EVAL) && (!last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready  = (state_ff == ST_IDLE) || finish;
   assign accept     = req_valid && req_ready;
   assign mul_enable = (state_ff != ST_EVAL) || finish;

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = ST_MK;
      end else if (finish) begin
         state_in = ST_IDLE;
      end else begin
         case (state_ff)
            ST_MK:   state_in = ST_JL;
            ST_JL:   state_in = ST_JU;
            ST_JU:   state_in = ST_EVAL;
            default: state_in = state_ff;
         endcase
      end
   end

   always_comb begin
      case (state_ff)
         ST_MK: begin
            op_a = product[tlc_pkg::MUL_A_W-1:0];
            op_b = tlc_pkg::MUL_B_W'(k_ff);
         end
         ST_JL: begin
            op_a = tlc_pkg::MUL_A_W'(jerk_lower_ff);
            op_b = dt_ff;
         end
         ST_JU: begin
            op_a = tlc_pkg::MUL_A_W'(jerk_upper_ff);
            op_b = dt_ff;
         end
         default: begin
            op_a = tlc_pkg::MUL_A_W'(req_speed);
            op_b = tlc_pkg::MUL_B_W'(req_speed);
         end
      endcase
   end

   tlc_mul u_mul (
      .clock   (clock),
      .enable  (mul_enable),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // jerk terms
   assign dt_in  = $signed({1'b0, t_ff}) - $signed({1'b0, prev_time_ff});
   assign da     = 17'(a_ff) - 17'(prev_accel_ff);
   assign da_ext = 27'(da);
   assign lhs_in = (da_ext <<< 10) - (da_ext <<< 4) - (da_ext <<< 3);

   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff    <= req_time_ms;
         v_ff    <= req_speed;
         a_ff    <= req_accel;
         k_ff    <= req_curvature;
         last_ff <= req_last_point;
      end
      if (state_ff == ST_MK) begin
         dt_ff  <= dt_in;
         lhs_ff <= lhs_in;
      end
      if (state_ff == ST_JL) begin
         lat_ff <= product[47:0];
      end
      if (state_ff == ST_JU) begin
         lo_ff <= product[33:0];
      end
   end

   // evaluation
   assign hi           = product[33:0];
   assign lhs_ext      = 34'(lhs_ff);
   assign lat_bound    = $signed({13'd0, lat_bound_ff, 20'd0});
   assign curv_bound_s = $signed({1'b0, curv_bound_ff});
   assign past         = t_ff > horizon_ff;

   assign jerk_fail = dt_ff[16] || (dt_ff == 17'sd0) || (lhs_ext < lo_ff) || (lhs_ext > hi);
   assign lat_fail  = (lat_ff > lat_bound) || (lat_ff < -lat_bound);

   always_comb begin
      if ((v_ff < SPEED_LOWER) || (v_ff > speed_upper_ff)) begin
         point_code = tlc_pkg::POINT_SPEED;
      end else if ((a_ff < accel_lower_ff) || (a_ff > accel_upper_ff)) begin
         point_code = tlc_pkg::POINT_ACCEL;
      end else if ((k_ff < -curv_bound_s) || (k_ff > curv_bound_s)) begin
         point_code = tlc_pkg::POINT_CURVATURE;
      end else begin
         point_code = tlc_pkg::POINT_NONE;
      end
      if (jerk_fail) begin
         pair_code = tlc_pkg::PAIR_JERK;
      end else if (lat_fail) begin
         pair_code = tlc_pkg::PAIR_LATERAL;
      end else begin
         pair_code = tlc_pkg::PAIR_NONE;
      end
   end

   always_comb begin
      prev_time_in  = prev_time_ff;
      prev_accel_in = prev_accel_ff;
      have_prev_in  = have_prev_ff;
      pstop_in      = pstop_ff;
      qstop_in      = qstop_ff;
      pfail_in      = pfail_ff;
      qfail_in      = qfail_ff;
      verdict_in    = verdict_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (finish) begin
         if (!pstop_ff) begin
            if (past) begin
               pstop_in = 1'b1;
            end else if (point_code != tlc_pkg::POINT_NONE) begin
               pfail_in = point_code;
               pstop_in = 1'b1;
            end
         end
         if (have_prev_ff && !qstop_ff) begin
            if (past) begin
               qstop_in = 1'b1;
            end else if (pair_code != tlc_pkg::PAIR_NONE) begin
               qfail_in = pair_code;
               qstop_in = 1'b1;
            end
         end
         prev_time_in  = t_ff;
         prev_accel_in = a_ff;
         have_prev_in  = 1'b1;
         if (last_ff) begin
            if (pfail_in != tlc_pkg::POINT_NONE) begin
               verdict_in = 3'(pfail_in);
            end else if (qfail_in != tlc_pkg::PAIR_NONE) begin
               verdict_in = tlc_pkg::VERDICT_PAIR_BASE + 3'(qfail_in);
            end else begin
               verdict_in = tlc_pkg::VERDICT_VALID;
            end
            rsp_valid_in  = 1'b1;
            prev_time_in  = '0;
            prev_accel_in = '0;
            have_prev_in  = 1'b0;
            pstop_in      = 1'b0;
            qstop_in      = 1'b0;
            pfail_in      = tlc_pkg::POINT_NONE;
            qfail_in      = tlc_pkg::PAIR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_time_ff  <= '0;
         prev_accel_ff <= '0;
         have_prev_ff  <= 1'b0;
         pstop_ff      <= 1'b0;
         qstop_ff      <= 1'b0;
         pfail_ff      <= tlc_pkg::POINT_NONE;
         qfail_ff      <= tlc_pkg::PAIR_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_time_ff  <= prev_time_in;
         prev_accel_ff <= prev_accel_in;
         have_prev_ff  <= have_prev_in;
         pstop_ff      <= pstop_in;
         qstop_ff      <= qstop_in;
         pfail_ff      <= pfail_in;
         qfail_ff      <= qfail_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule
